/* rtl/core/sorted_deadline_timer_queue_defines.svh */
// ---------------------------------------------------------------------------
// Sorted deadline timer queue assertion macros
// Shared property forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef SORTED_DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_DEFINES_SVH
// implication under clock and reset
`define SDTQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication under clock and reset
`define SDTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* rtl/core/sdtq_pkg.sv */
// ---------------------------------------------------------------------------
// Sorted deadline timer queue package
// Widths, codes and sequencer states.
// ---------------------------------------------------------------------------
package sdtq_pkg;
	localparam int Depth = 16;
	localparam int IdxW  = $clog2(Depth);
	localparam int CntW  = $clog2(Depth + 1);
	localparam logic [47:0] Max48 = '1;

	typedef enum logic [1:0] {
		MODE_CREATE = 2'd0,
		MODE_CANCEL = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_TICK   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_CREATED  = 3'd0,
		ST_FULL     = 3'd1,
		ST_CANCELED = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_CLEARED  = 3'd4,
		ST_EXPIRED  = 3'd5,
		ST_NONE     = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_POP,
		S_INSERT,
		S_EMIT,
		S_FINAL,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [47:0] dl;
		logic [31:0] per;
		logic [7:0]  own;
		logic [15:0] id;
		logic        pf;
	} entry_t;
endpackage

/* rtl/core/sorted_deadline_timer_queue.sv */
// ---------------------------------------------------------------------------
// Sorted deadline timer queue
// Up to 16 timers in deadline order with create, cancel, owner clear, tick.
// ---------------------------------------------------------------------------
// Usage: one command item enters on s_axis (mode, owner, timer_id, interval,
// one_shot, now packed in tdata). Results leave on m_axis, one per item
// except a tick, which gives one result per expired timer, or one result
// when none is due; tlast marks the final result of an item.
// One item is handled at a time; s_axis_tready is low from the accept until
// the cycle after its last result is taken. A tick walks the queue, then per
// expired timer pops the head and bubbles a re-armed timer back in, then
// sends one result per cycle while m_axis_tready is high.
// A stalled m_axis receiver holds the result and the sequencer.
// Reset empties the queue and zeroes the id counter; entry contents are
// left unset since only entries below the count are read.
// ---------------------------------------------------------------------------
module sorted_deadline_timer_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// mode[1:0], owner[9:2], timer_id[25:10], interval[57:26], one_shot[58], now[106:59]
	input  logic [111:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status[2:0], result_id[18:3], result_owner[26:19], removed_count[31:27],
	// ready_res[32], time_to_next[80:33], queue_count[85:81]
	output logic [87:0]  m_axis_tdata,
	output logic         m_axis_tlast
);
	import sdtq_pkg::*;

	state_t state_q, state_nx;
	entry_t ent_q [Depth];
	logic [15:0] xid_q [Depth];
	logic [7:0]  xown_q [Depth];
	logic [CntW-1:0] cnt_q, i_q, due_q, gone_q, wr_q, j_q;
	logic [15:0] idc_q;
	mode_t mode_q;
	logic [7:0]  own_q;
	logic [15:0] tid_q;
	logic [31:0] iv_q;
	logic        once_q;
	logic [47:0] now_q;
	logic        hit_q;
	entry_t      ins_q;
	logic [2:0]  st_q;
	logic [15:0] rid_q;
	logic [7:0]  rown_q;
	logic [4:0]  rc_q;
	logic        last_q, ovalid_q;

	logic [IdxW-1:0] ix, ixp, ixm, wx, jx;
	entry_t cur;
	logic [48:0] sum;
	logic [47:0] sat;
	logic        in_acc, out_acc, ld;
	logic        scan_done, shift_done, pop_done, due_hit, keep_cur;
	logic        keep, ins_move, ins_done, last_due;
	logic [2:0]  fin_st;
	logic [15:0] fin_rid;
	logic [4:0]  fin_rc;
	logic        rdy;
	logic [47:0] ttn;

	assign ix  = i_q[IdxW-1:0];
	assign ixp = ix + 1'b1;
	assign ixm = ix - 1'b1;
	assign wx  = wr_q[IdxW-1:0];
	assign jx  = j_q[IdxW-1:0];
	assign cur = ent_q[ix];
	assign sum = {1'b0, now_q} + {17'd0, (state_q == S_POP) ? ent_q[0].per : iv_q};
	assign sat = sum[48] ? Max48 : sum[47:0];
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = ovalid_q && m_axis_tready;
	assign ld = ((state_q == S_EMIT) || (state_q == S_FINAL)) && (!ovalid_q || m_axis_tready);

	assign scan_done  = (mode_q == MODE_CREATE) || (mode_q == MODE_CLEAR) || (i_q >= cnt_q);
	assign shift_done = (i_q >= cnt_q);
	assign pop_done   = (i_q + 1'b1 >= cnt_q);
	assign due_hit    = (mode_q == MODE_TICK) && (i_q < cnt_q) && (cur.dl <= now_q)
		&& (due_q == i_q);
	assign keep_cur   = !(mode_q == MODE_CLEAR && cur.own == own_q)
		&& !(mode_q == MODE_CANCEL && hit_q && i_q == due_q);
	assign keep       = (mode_q != MODE_TICK) || ins_q.pf;
	assign ins_move   = keep && (i_q != '0) && (ins_q.dl < ent_q[ixm].dl);
	assign ins_done   = !ins_move;
	assign last_due   = (j_q + 1'b1 >= due_q);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE:   if (in_acc) state_nx = S_SCAN;
			S_SCAN:   if (scan_done) begin
				case (mode_q)
					MODE_CREATE: state_nx = (cnt_q < CntW'(Depth)) ? S_INSERT : S_FINAL;
					MODE_TICK:   state_nx = (due_q != '0) ? S_POP : S_FINAL;
					default:     state_nx = S_SHIFT;
				endcase
			end
			S_SHIFT:  if (shift_done) state_nx = S_FINAL;
			S_POP:    if (pop_done) state_nx = S_INSERT;
			S_INSERT: if (ins_done) begin
				if (mode_q != MODE_TICK) state_nx = S_FINAL;
				else state_nx = last_due ? S_EMIT : S_POP;
			end
			S_EMIT:   if (ld && last_due) state_nx = S_OUT;
			S_FINAL:  if (ld) state_nx = S_OUT;
			S_OUT:    if (!ovalid_q || m_axis_tready) state_nx = S_IDLE;
			default:  state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		rdy = (cnt_q != '0) && (ent_q[0].dl <= now_q);
		ttn = ((cnt_q != '0) && !rdy) ? ent_q[0].dl - now_q : 48'd0;
		s_axis_tready = (state_q == S_IDLE);
		m_axis_tvalid = ovalid_q;
		m_axis_tlast  = last_q;
		m_axis_tdata  = {2'b00, cnt_q, ttn, rdy, rc_q, rown_q, rid_q, st_q};
		fin_rid = '0;
		fin_rc  = '0;
		case (mode_q)
			MODE_CREATE: begin
				fin_st  = hit_q ? ST_CREATED : ST_FULL;
				fin_rid = hit_q ? idc_q : 16'd0;
			end
			MODE_CANCEL: fin_st = hit_q ? ST_CANCELED : ST_NOTFOUND;
			MODE_CLEAR: begin
				fin_st = ST_CLEARED;
				fin_rc = 5'(gone_q);
			end
			default: fin_st = ST_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			i_q      <= '0;
			due_q    <= '0;
			gone_q   <= '0;
			wr_q     <= '0;
			j_q      <= '0;
			idc_q    <= '0;
			mode_q   <= MODE_CREATE;
			own_q    <= '0;
			tid_q    <= '0;
			iv_q     <= '0;
			once_q   <= 1'b0;
			now_q    <= '0;
			hit_q    <= 1'b0;
			ins_q    <= '0;
			st_q     <= '0;
			rid_q    <= '0;
			rown_q   <= '0;
			rc_q     <= '0;
			last_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ld) ovalid_q <= 1'b1;
			else if (out_acc) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_acc) begin
					mode_q <= mode_t'(s_axis_tdata[1:0]);
					own_q  <= s_axis_tdata[9:2];
					tid_q  <= s_axis_tdata[25:10];
					iv_q   <= s_axis_tdata[57:26];
					once_q <= s_axis_tdata[58];
					now_q  <= s_axis_tdata[106:59];
					i_q <= '0; wr_q <= '0; due_q <= '0; gone_q <= '0; j_q <= '0;
					hit_q <= 1'b0;
				end
				S_SCAN: begin
					// find due prefix, first cancel hit, or stage a new timer
					case (mode_q)
						MODE_CREATE: begin
							hit_q <= (cnt_q < CntW'(Depth));
							ins_q <= '{dl: sat, per: iv_q, own: own_q, id: idc_q, pf: !once_q};
							i_q   <= cnt_q;
						end
						MODE_CANCEL: if (i_q < cnt_q) begin
							i_q <= i_q + 1'b1;
							if (!hit_q && cur.own == own_q && cur.id == tid_q) begin
								hit_q <= 1'b1;
								due_q <= i_q;
							end
						end else i_q <= '0;
						MODE_TICK: if (i_q < cnt_q) begin
							i_q <= i_q + 1'b1;
							if (due_hit) due_q <= due_q + 1'b1;
						end else i_q <= '0;
						default: ;
					endcase
				end
				S_SHIFT: if (i_q < cnt_q) begin
					// compact surviving entries downward
					i_q <= i_q + 1'b1;
					if (mode_q == MODE_CLEAR && cur.own == own_q) gone_q <= gone_q + 1'b1;
					else if (keep_cur) wr_q <= wr_q + 1'b1;
				end else cnt_q <= wr_q;
				S_POP: begin
					// take the head and close the gap
					if (i_q == '0)
						ins_q <= '{dl: sat, per: ent_q[0].per, own: ent_q[0].own,
							id: ent_q[0].id, pf: ent_q[0].pf};
					if (!pop_done) i_q <= i_q + 1'b1;
					else begin
						cnt_q <= cnt_q - 1'b1;
						i_q   <= cnt_q - 1'b1;
					end
				end
				S_INSERT: begin
					// bubble the staged timer down one slot per cycle
					if (ins_move) i_q <= i_q - 1'b1;
					else begin
						if (keep) cnt_q <= cnt_q + 1'b1;
						if (mode_q == MODE_TICK) begin
							j_q <= last_due ? '0 : j_q + 1'b1;
							i_q <= '0;
						end
					end
				end
				S_EMIT: if (ld) begin
					st_q   <= ST_EXPIRED;
					rid_q  <= xid_q[jx];
					rown_q <= xown_q[jx];
					rc_q   <= '0;
					last_q <= last_due;
					j_q    <= j_q + 1'b1;
				end
				S_FINAL: if (ld) begin
					st_q   <= fin_st;
					rid_q  <= fin_rid;
					rown_q <= '0;
					rc_q   <= fin_rc;
					last_q <= 1'b1;
					if (mode_q == MODE_CREATE && hit_q) idc_q <= idc_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_SCAN: if (due_hit) begin
				xid_q[ix]  <= cur.id;
				xown_q[ix] <= cur.own;
			end
			S_SHIFT:  if (i_q < cnt_q && keep_cur) ent_q[wx] <= cur;
			S_POP:    if (!pop_done) ent_q[ix] <= ent_q[ixp];
			S_INSERT: if (ins_move) ent_q[ix] <= ent_q[ixm];
				else if (keep) ent_q[ix] <= ins_q;
			default: ;
		endcase
	end
endmodule

/* rtl/core/sdtq_checker.sv */
// ---------------------------------------------------------------------------
// Sorted deadline timer queue port checker
// Handshake and result-shape checks seen from the ports.
// ---------------------------------------------------------------------------
`include "sorted_deadline_timer_queue_defines.svh"
module sdtq_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [87:0]  m_axis_tdata,
	input logic         m_axis_tlast
);
	`SDTQ_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result dropped while stalled")
	`SDTQ_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while busy")
	`SDTQ_ASSERT_IMP(a_count, m_axis_tvalid, m_axis_tdata[85:81] <= 5'd16, "queue count out of range")
	`SDTQ_ASSERT_IMP(a_ready, m_axis_tvalid && m_axis_tdata[32], m_axis_tdata[80:33] == 48'd0, "ready with nonzero wait")
endmodule

bind sorted_deadline_timer_queue sdtq_checker u_sdtq_checker (.*);
